/* src/recv_queue_overload_percentile_macros.svh */
// ----------------------------------------------------------------------------
// recv_queue_overload_percentile_macros
// Assertion macros for the receive-queue overload block.
// ----------------------------------------------------------------------------
`ifndef RECV_QUEUE_OVERLOAD_PERCENTILE_MACROS_SVH
`define RECV_QUEUE_OVERLOAD_PERCENTILE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define RQOP_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define RQOP_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);
`endif

/* src/rqop_pkg.sv */
// ----------------------------------------------------------------------------
// rqop_pkg
// Shared types and constants of the receive-queue overload block.
// ----------------------------------------------------------------------------
package rqop_pkg;
  localparam int NODES_DEF = 64;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_FORGET = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_PERCENTILE = 2'd1;
  localparam logic [1:0] REG_FRESHNESS = 2'd2;

  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_RISE = 2'd1;
  localparam logic [1:0] CHG_FALL = 2'd2;

  // Entry word layout: util(7) last(64) delta(64) size(32).
  localparam int ENTRY_W = 7 + 64 + 64 + 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  node;
    logic signed [31:0] occupancy;
    logic [31:0] capacity;
    logic [63:0] bytes_received;
  } in_item_t;

  typedef struct packed {
    logic        overloaded;
    logic [1:0]  report_change;
    logic [6:0]  sample_count;
    logic [6:0]  chosen_pct;
    logic [6:0]  stored_pct;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  util;
    logic [63:0] last;
    logic [63:0] delta;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SREAD, ST_SWRITE, ST_SCAN, ST_SCHK, ST_RANK_MUL,
    ST_RANK, ST_HSCAN, ST_DONE, ST_OUT
  } state_t;
endpackage

/* src/rqop_ram.sv */
// ----------------------------------------------------------------------------
// rqop_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rqop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/rqop_div.sv */
// ----------------------------------------------------------------------------
// rqop_div
// Restoring divider: 100*occ / cap, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rqop_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [6:0]  quotient
);
  logic [38:0] num;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], num[38]} - {1'b0, divisor};

  // One shift-subtract step per cycle over the 39 dividend bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= dividend;
        rem  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          num <= {num[37:0], 1'b1};
        end else begin
          rem <= {rem[31:0], num[38]};
          num <= {num[37:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd38) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient never exceeds 100.
  assign quotient = num[6:0];
endmodule

/* src/recv_queue_overload_percentile.sv */
// ----------------------------------------------------------------------------
// recv_queue_overload_percentile
// Per-node receive-queue sample table with percentile overload detection.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A sample waits for the bit-serial
// utilization divider. A tick walks the entry RAM one node per cycle, then,
// if any entry qualified, walks a 128-bin histogram up to the chosen bin.
// After reset the histogram is swept clear before the first transaction is
// taken. After a tick that found a qualifying entry the same sweep starts
// at the end of the histogram walk, and no transaction is taken until it
// finishes.
module recv_queue_overload_percentile #(
  parameter int NODES = rqop_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rqop_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rqop_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RD = (NODES > 1) ? NODES : 2;
  localparam int CW = $clog2(NODES + 1);

  rqop_pkg::state_t state, state_next;
  rqop_pkg::in_item_t item;

  logic [6:0]  threshold_pct, percentile;
  logic [15:0] freshness_factor;
  logic        overloaded_flag, reported_flag;
  logic [NODES-1:0] entry_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_pct    <= 7'd50;
      percentile       <= 7'd99;
      freshness_factor <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        rqop_pkg::REG_THRESHOLD:  threshold_pct    <= cfg_data[6:0];
        rqop_pkg::REG_PERCENTILE: percentile       <= cfg_data[6:0];
        rqop_pkg::REG_FRESHNESS:  freshness_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry RAM.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  rqop_pkg::entry_t ram_wdata, ram_rdata;

  rqop_ram #(.WIDTH(rqop_pkg::ENTRY_W), .DEPTH(RD)) u_entry (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Histogram RAM, one count per utilization value.
  logic          hist_we;
  logic [6:0]    hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata, hist_rdata;
  logic          h_we;
  logic [6:0]    h_waddr;
  logic [CW-1:0] h_wdata;

  rqop_ram #(.WIDTH(CW), .DEPTH(128)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // Divider for the utilization percentage. The dividend is taken from the
  // incoming transaction at the start pulse.
  logic        div_start, div_done;
  logic [31:0] occ_clamp;
  logic [38:0] div_num;
  logic [6:0]  div_q;

  assign occ_clamp = ($unsigned(in_data.occupancy) > in_data.capacity) ?
                     in_data.capacity : $unsigned(in_data.occupancy);
  assign div_num = 39'(occ_clamp) * 39'd100;

  rqop_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(item.capacity), .done(div_done), .quotient(div_q)
  );

  // Working registers.
  logic [AW:0]   idx;
  logic [7:0]    bin;
  logic [CW-1:0] n_count, acc, rank;
  logic [CW+6:0] rank_prod;
  logic [6:0]    util_q, chosen;
  logic          chk_valid;
  logic [AW-1:0] chk_idx;
  logic [47:0]   need;
  logic          qual;
  logic          clear_busy;
  logic [1:0]    change;
  logic [6:0]    stored;
  logic [CW+6:0] rank_q;
  logic [CW+24:0] rank_mul;

  assign need = (48'(ram_rdata.size) * 48'(freshness_factor)) >> 8;
  assign qual = (ram_rdata.delta >= 64'(need)) || (ram_rdata.util >= threshold_pct);
  // Divide the rank product by 100 with a reciprocal multiply; the result is
  // exact for products below about 199000.
  assign rank_mul = (CW+25)'(rank_prod) * (CW+25)'(18'd167773);
  assign rank_q   = (CW+7)'(rank_mul >> 24);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      rqop_pkg::ST_IDLE: begin
        if (in_valid && !clear_busy) begin
          state_next = rqop_pkg::ST_DONE;
          if (in_data.operation == rqop_pkg::OP_TICK) begin
            state_next = rqop_pkg::ST_SCAN;
          end else if (in_data.operation == rqop_pkg::OP_SAMPLE &&
                       32'(in_data.node) < NODES &&
                       !in_data.occupancy[31] && in_data.capacity != 32'd0) begin
            state_next = rqop_pkg::ST_DIV;
          end
        end
      end
      rqop_pkg::ST_DIV:    if (div_done) state_next = rqop_pkg::ST_SWRITE;
      rqop_pkg::ST_SWRITE: state_next = rqop_pkg::ST_DONE;
      rqop_pkg::ST_SCAN:   if (idx == (AW+1)'(NODES)) state_next = rqop_pkg::ST_SCHK;
      rqop_pkg::ST_SCHK:   state_next = (n_count == '0) ? rqop_pkg::ST_DONE :
                                                         rqop_pkg::ST_RANK_MUL;
      rqop_pkg::ST_RANK_MUL: state_next = rqop_pkg::ST_RANK;
      rqop_pkg::ST_RANK:   state_next = rqop_pkg::ST_HSCAN;
      rqop_pkg::ST_HSCAN:  if (bin[7] || (acc + hist_rdata) > rank)
                             state_next = rqop_pkg::ST_DONE;
      rqop_pkg::ST_DONE:   state_next = rqop_pkg::ST_OUT;
      rqop_pkg::ST_OUT:    if (!out_stall) state_next = rqop_pkg::ST_IDLE;
      default:             state_next = rqop_pkg::ST_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = item.node[AW-1:0];
    ram_raddr  = item.node[AW-1:0];
    ram_wdata  = '0;
    hist_we    = 1'b0;
    hist_waddr = 7'd0;
    hist_wdata = '0;
    hist_raddr = bin[6:0];
    case (state)
      rqop_pkg::ST_IDLE: begin
        div_start = in_valid && !clear_busy;
        ram_raddr = in_data.node[AW-1:0];
      end
      rqop_pkg::ST_SWRITE: begin
        ram_we = 1'b1;
        ram_wdata.util  = div_q;
        ram_wdata.last  = item.bytes_received;
        ram_wdata.delta = entry_valid[item.node[AW-1:0]] ?
                          item.bytes_received - ram_rdata.last : item.bytes_received;
        ram_wdata.size  = item.capacity;
      end
      rqop_pkg::ST_SCAN: begin
        ram_raddr = idx[AW-1:0];
        // Count a qualifying entry read in the previous cycle.
        if (chk_valid && entry_valid[chk_idx] && qual) begin
          hist_raddr = ram_rdata.util;
        end
      end
      rqop_pkg::ST_HSCAN: begin
        hist_raddr = 7'(bin + 8'd1);
        // Clear bins on the way so the histogram is empty for the next tick.
        hist_we    = 1'b1;
        hist_waddr = bin[6:0];
      end
      default: ;
    endcase
    // Background sweep that clears one histogram bin per cycle.
    if (clear_busy) begin
      hist_we    = 1'b1;
      hist_waddr = bin[6:0];
    end
  end

  // Histogram increments during the scan use a read then write pipeline.
  logic          inc_pend;
  logic [6:0]    inc_bin;
  logic          fwd;
  logic          fwd3;
  logic [CW-1:0] base;
  logic          inc_pend2;
  logic [6:0]    inc_bin2;
  logic [CW-1:0] inc_val2;
  logic          inc_pend3;
  logic [6:0]    inc_bin3;
  logic [CW-1:0] inc_val3;

  // The RAM returns the old count when a read meets a write to the same bin,
  // so the two most recent increments are forwarded.
  assign fwd  = inc_pend2 && (inc_bin2 == inc_bin);
  assign fwd3 = inc_pend3 && (inc_bin3 == inc_bin);
  assign base = fwd ? inc_val2 : (fwd3 ? inc_val3 : hist_rdata);

  // Main sequential logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rqop_pkg::ST_IDLE;
      entry_valid     <= '0;
      overloaded_flag <= 1'b0;
      reported_flag   <= 1'b0;
      clear_busy      <= 1'b1;
      bin             <= 8'd0;
      chk_valid       <= 1'b0;
      inc_pend        <= 1'b0;
      inc_pend2       <= 1'b0;
      inc_pend3       <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_busy) begin
        bin <= bin + 8'd1;
        if (bin == 8'd127) begin
          clear_busy <= 1'b0;
        end
      end
      case (state)
        rqop_pkg::ST_IDLE: begin
          if (in_valid && !clear_busy) begin
            item      <= in_data;
            change    <= rqop_pkg::CHG_NONE;
            stored    <= 7'd0;
            n_count   <= '0;
            chosen    <= 7'd0;
            idx       <= '0;
            chk_valid <= 1'b0;
            inc_pend  <= 1'b0;
            if (32'(in_data.node) < NODES &&
                ((in_data.operation == rqop_pkg::OP_FORGET) ||
                 (in_data.operation == rqop_pkg::OP_SAMPLE &&
                  (in_data.occupancy[31] || in_data.capacity == 32'd0)))) begin
              entry_valid[in_data.node[AW-1:0]] <= 1'b0;
            end
          end
        end
        rqop_pkg::ST_SWRITE: begin
          entry_valid[item.node[AW-1:0]] <= 1'b1;
          stored <= div_q;
        end
        rqop_pkg::ST_SCAN: begin
          chk_valid <= (idx < (AW+1)'(NODES));
          chk_idx   <= idx[AW-1:0];
          idx       <= idx + 1'b1;
          inc_pend  <= chk_valid && entry_valid[chk_idx] && qual;
          inc_bin   <= ram_rdata.util;
          if (chk_valid && entry_valid[chk_idx] && qual) begin
            n_count <= n_count + 1'b1;
          end
        end
        rqop_pkg::ST_SCHK: begin
          inc_pend <= 1'b0;
        end
        default: ;
      endcase
      // Write back a pending increment, forwarding recent writes to the same bin.
      inc_pend2 <= inc_pend && (state == rqop_pkg::ST_SCAN || state == rqop_pkg::ST_SCHK);
      inc_bin2  <= inc_bin;
      inc_val2  <= base + 1'b1;
      inc_pend3 <= inc_pend2;
      inc_bin3  <= inc_bin2;
      inc_val3  <= inc_val2;
      case (state)
        rqop_pkg::ST_SCHK: begin
          if (n_count == '0) begin
            overloaded_flag <= 1'b0;
          end
        end
        rqop_pkg::ST_RANK_MUL: begin
          rank_prod <= (CW+7)'(n_count) * (CW+7)'(percentile);
        end
        rqop_pkg::ST_RANK: begin
          rank <= (rank_q > (CW+7)'(n_count - 1'b1)) ? n_count - 1'b1 :
                  rank_q[CW-1:0];
          acc  <= '0;
          bin  <= 8'd0;
        end
        rqop_pkg::ST_HSCAN: begin
          acc <= acc + hist_rdata;
          bin <= bin + 8'd1;
          if (bin[7] || (acc + hist_rdata) > rank) begin
            chosen <= bin[6:0];
            overloaded_flag <= (bin[6:0] >= threshold_pct);
            // Remaining bins are cleared by a background sweep.
            clear_busy <= 1'b1;
            bin <= 8'd0;
          end
        end
        rqop_pkg::ST_DONE: begin
          if (item.operation == rqop_pkg::OP_TICK &&
              overloaded_flag != reported_flag) begin
            change        <= overloaded_flag ? rqop_pkg::CHG_RISE : rqop_pkg::CHG_FALL;
            reported_flag <= overloaded_flag;
          end
        end
        default: ;
      endcase
    end
  end

  // Histogram write port sharing: increments take priority during the scan.
  always_comb begin
    h_we = hist_we;
    h_waddr = hist_waddr;
    h_wdata = hist_wdata;
    if (inc_pend2) begin
      h_we = 1'b1;
      h_waddr = inc_bin2;
      h_wdata = inc_val2;
    end
  end

  // Output side.
  assign in_stall  = (state != rqop_pkg::ST_IDLE) || clear_busy;
  assign out_valid = (state == rqop_pkg::ST_OUT);
  always_comb begin
    out_data.overloaded    = overloaded_flag;
    out_data.report_change = change;
    out_data.sample_count  = 7'(n_count);
    out_data.chosen_pct    = chosen;
    out_data.stored_pct    = stored;
  end

  `include "recv_queue_overload_percentile_macros.svh"

  `RQOP_ASSERT_IMP(a_no_accept_busy, clk, rst, in_valid && !in_stall,
    state == rqop_pkg::ST_IDLE, "input accepted while busy")
  `RQOP_ASSERT_IMP(a_change_tick, clk, rst, out_valid && change != rqop_pkg::CHG_NONE,
    item.operation == rqop_pkg::OP_TICK, "change reported outside a tick")
  `RQOP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result changed")
endmodule

/* dv/tb_recv_queue_overload_percentile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recv_queue_overload_percentile
// Self-checking testbench for the receive-queue overload block. A behavioral
// model of the node table predicts every result; directed and random sample,
// tick and forget transactions run under several register settings with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_recv_queue_overload_percentile;
  localparam int NUM_NODES = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Holds the predicted node table and compares results in order.
  class overload_scoreboard;
    bit          valid_q[NUM_NODES];
    logic [6:0]  util_q[NUM_NODES];
    logic [63:0] last_q[NUM_NODES];
    logic [63:0] delta_q[NUM_NODES];
    logic [31:0] size_q[NUM_NODES];
    bit          overloaded;
    bit          reported;
    logic [6:0]  thresh = 7'd50;
    logic [6:0]  pctl = 7'd99;
    logic [15:0] fresh = 16'd256;
    rqop_pkg::out_item_t pending[$];
    int          errors;
    int          checked;
    int          ticks;
    int          raised;

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        rqop_pkg::REG_THRESHOLD:  thresh = val[6:0];
        rqop_pkg::REG_PERCENTILE: pctl = val[6:0];
        rqop_pkg::REG_FRESHNESS:  fresh = val;
        default: ;
      endcase
    endfunction

    // Apply one accepted input transaction and queue its expected result.
    function void note_input(rqop_pkg::in_item_t it);
      rqop_pkg::out_item_t res;
      int          hist[128];
      int          cnt;
      int          rank;
      int          acc;
      logic [63:0] occ;
      logic [63:0] need;
      int          n;
      res = '0;
      n = it.node;
      case (it.operation)
        rqop_pkg::OP_SAMPLE: begin
          if (it.occupancy[31] || it.capacity == 0) begin
            valid_q[n] = 0;
          end else begin
            occ = {32'd0, it.occupancy};
            if (occ > {32'd0, it.capacity}) occ = {32'd0, it.capacity};
            res.stored_pct = 7'((occ * 64'd100) / {32'd0, it.capacity});
            delta_q[n] = valid_q[n] ? it.bytes_received - last_q[n] : it.bytes_received;
            last_q[n] = it.bytes_received;
            size_q[n] = it.capacity;
            util_q[n] = res.stored_pct;
            valid_q[n] = 1;
          end
        end
        rqop_pkg::OP_TICK: begin
          ticks++;
          foreach (hist[i]) hist[i] = 0;
          cnt = 0;
          for (int i = 0; i < NUM_NODES; i++) begin
            need = ({32'd0, size_q[i]} * {48'd0, fresh}) >> 8;
            if (valid_q[i] && (delta_q[i] >= need || util_q[i] >= thresh)) begin
              hist[util_q[i]]++;
              cnt++;
            end
          end
          res.sample_count = 7'(cnt);
          if (cnt == 0) begin
            overloaded = 0;
          end else begin
            rank = (cnt * pctl) / 100;
            if (rank > cnt - 1) rank = cnt - 1;
            acc = 0;
            for (int v = 0; v < 128; v++) begin
              acc += hist[v];
              if (acc > rank) begin
                res.chosen_pct = 7'(v);
                break;
              end
            end
            overloaded = res.chosen_pct >= thresh;
          end
          if (overloaded != reported) begin
            res.report_change = overloaded ? rqop_pkg::CHG_RISE : rqop_pkg::CHG_FALL;
            reported = overloaded;
            if (overloaded) raised++;
          end
        end
        rqop_pkg::OP_FORGET: valid_q[n] = 0;
        default: ;
      endcase
      res.overloaded = overloaded;
      pending = {pending, res};
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(rqop_pkg::out_item_t got);
      rqop_pkg::out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.overloaded !== want.overloaded)
        report("overloaded", got.overloaded, want.overloaded);
      if (got.report_change !== want.report_change)
        report("report_change", got.report_change, want.report_change);
      if (got.sample_count !== want.sample_count)
        report("sample_count", got.sample_count, want.sample_count);
      if (got.chosen_pct !== want.chosen_pct)
        report("chosen_pct", got.chosen_pct, want.chosen_pct);
      if (got.stored_pct !== want.stored_pct)
        report("stored_pct", got.stored_pct, want.stored_pct);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  rqop_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_stall;
  rqop_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  overload_scoreboard sb;
  bit          calm;
  int          sent;

  recv_queue_overload_percentile i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit: it allows for the slowest tick with its histogram clear,
  // plus stalls and gaps.
  initial begin
    #20ms;
    $display("recv_queue_overload_percentile regression: fail");
    $finish;
  end

  // Random receiver stalls in short bursts; results are checked at the rising edge.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Send one transaction and wait until it is accepted. Valid stays high after
  // acceptance; the block stalls after every transaction.
  task automatic send_item(rqop_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic rqop_pkg::in_item_t make_item(logic [1:0] op, logic [5:0] n,
                                                   logic [31:0] occ, logic [31:0] cap,
                                                   logic [63:0] b);
    rqop_pkg::in_item_t it;
    it.operation = op;
    it.node = n;
    it.occupancy = occ;
    it.capacity = cap;
    it.bytes_received = b;
    return it;
  endfunction

  // Mostly well-formed samples on a small node set; ticks, forgets, unused ops too.
  function automatic rqop_pkg::in_item_t random_item();
    logic [31:0] cap;
    logic [31:0] occ;
    logic [63:0] b;
    int          r;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: cap = $urandom;
      1: cap = $urandom_range(1, 200);
      default: cap = $urandom_range(1000, 100000);
    endcase
    case ($urandom_range(0, 3))
      0: occ = $urandom;
      default: occ = $urandom_range(0, cap > 32'h7fffffff ? 32'h7fffffff : cap);
    endcase
    b = {$urandom, $urandom};
    if (r < 3) return make_item(OP_UNUSED, 6'($urandom), $urandom, $urandom, b);
    if (r < 8) return make_item(rqop_pkg::OP_SAMPLE, 6'($urandom),
                                $urandom_range(0, 9) == 0 ? 32'hffffffff : occ,
                                $urandom_range(0, 9) == 0 ? 32'd0 : cap, b);
    if (r < 13) return make_item(rqop_pkg::OP_FORGET, 6'($urandom), $urandom, $urandom, b);
    if (r < 33) return make_item(rqop_pkg::OP_TICK, 6'($urandom), $urandom, $urandom, b);
    return make_item(rqop_pkg::OP_SAMPLE,
                     $urandom_range(0, 63) < 48 ? 6'($urandom_range(0, 15)) : 6'($urandom),
                     occ, cap, b);
  endfunction

  initial begin
    logic [15:0] thr_set[5] = '{16'd0, 16'd100, 16'd127, 16'd30, 16'd75};
    logic [15:0] pct_set[5] = '{16'd0, 16'd100, 16'd127, 16'd50, 16'd90};
    logic [15:0] frs_set[5] = '{16'd0, 16'hffff, 16'd128, 16'd512, 16'd64};
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = rqop_pkg::REG_THRESHOLD;
    cfg_data = '0;
    calm = 0;
    sent = 0;
    repeat (7) @(negedge clk);
    rst = 0;

    // Directed: field extremes, every operation, removal and unused cases.
    send_item(make_item(rqop_pkg::OP_TICK, 6'd0, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd0, 32'd0, 32'hffffffff, 64'd0));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd63, 32'h7fffffff, 32'd1,
                        64'hffffffffffffffff));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd1, 32'd50, 32'd100, 64'd1000));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd1, 32'd99, 32'd100, 64'd500));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd2, 32'd1, 32'd3, 64'hffffffffffffffff));
    send_item(make_item(rqop_pkg::OP_TICK, 6'd0, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd2, 32'h80000000, 32'd5, 64'd0));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd63, 32'd5, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_SAMPLE, 6'd3, 32'hffffffff, 32'hffffffff, 64'd7));
    send_item(make_item(OP_UNUSED, 6'h3f, 32'hffffffff, 32'hffffffff,
                        64'hffffffffffffffff));
    send_item(make_item(rqop_pkg::OP_TICK, 6'd0, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_FORGET, 6'd1, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_FORGET, 6'd40, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_TICK, 6'd0, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_FORGET, 6'd0, 32'd0, 32'd0, 64'd0));
    send_item(make_item(rqop_pkg::OP_TICK, 6'd0, 32'd0, 32'd0, 64'd0));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph > 0) begin
        write_reg(rqop_pkg::REG_THRESHOLD, thr_set[ph - 1]);
        write_reg(rqop_pkg::REG_PERCENTILE, pct_set[ph - 1]);
        write_reg(rqop_pkg::REG_FRESHNESS, frs_set[ph - 1]);
        cfg_we <= 0;
      end
      calm = ph == 5;
      for (int k = 0; k < 240; k++) send_item(random_item());
    end

    wait_drained();
    $display("Covered %0d transactions, %0d results, %0d ticks, %0d overload rises.",
             sent, sb.checked, sb.ticks, sb.raised);
    if (sb.errors == 0) begin
      $display("recv_queue_overload_percentile regression: pass");
    end else begin
      $display("recv_queue_overload_percentile regression: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+src
src/rqop_pkg.sv
src/rqop_ram.sv
src/rqop_div.sv
src/recv_queue_overload_percentile.sv
dv/tb_recv_queue_overload_percentile.sv
